// File: src/tpsg_pkg.sv
package tpsg_pkg;

	// field widths
	localparam int AMP_W  = 10;
	localparam int STEP_W = 16;
	localparam int TICK_W = 32;
	localparam int VOLT_W = 19;
	localparam int LINE_W = 20;
	localparam int MAG_W  = 16;

	// defaults for the top-level parameters
	localparam int DEF_SINE_TABLE_DEPTH = 256;
	localparam int DEF_PHASE_WIDTH      = 16;

	// register reset values
	localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(230);
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(655);

	// register map (word index = paddr[2])
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_AMPLITUDE  = 1'b0;
	localparam logic REG_PHASE_STEP = 1'b1;

	// input / output stream layout
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 152;
	localparam int OFS_TICKS = 0;
	localparam int OFS_A     = OFS_TICKS + TICK_W;
	localparam int OFS_B     = OFS_A + VOLT_W;
	localparam int OFS_C     = OFS_B + VOLT_W;
	localparam int OFS_AB    = OFS_C + VOLT_W;
	localparam int OFS_BC    = OFS_AB + LINE_W;
	localparam int OFS_CA    = OFS_BC + LINE_W;
	localparam int PAYLOAD_W = OFS_CA + LINE_W;

	// sine table math
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] Q15_ONE     = 64'd32768;
	localparam int ROUND_SHIFT = 7;

	typedef struct packed {
		logic [AMP_W-1:0]  amplitude;
		logic [STEP_W-1:0] phase_step;
	} cfg_t;

	// Q1.15 sine of a Q30 angle, Taylor series up to x^13.
	// Evaluated at elaboration only.
	function automatic logic [MAG_W-1:0] sine_q15(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        r;
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + signed'(term);
		if (sum < 0) begin
			sum = '0;
		end
		r = (unsigned'(sum) + 64'd16384) >> 15;
		if (r > Q15_ONE) begin
			r = Q15_ONE;
		end
		return r[MAG_W-1:0];
	endfunction

endpackage

// File: src/tpsg_cfg_regs.sv
module tpsg_cfg_regs
	import tpsg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [AMP_W-1:0]  amplitude_q;
	logic [STEP_W-1:0] phase_step_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q  <= AMP_RESET;
			phase_step_q <= STEP_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_AMPLITUDE:  amplitude_q  <= pwdata[AMP_W-1:0];
				REG_PHASE_STEP: phase_step_q <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_AMPLITUDE:  prdata = PDATA_W'(amplitude_q);
			REG_PHASE_STEP: prdata = PDATA_W'(phase_step_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.amplitude  = amplitude_q;
	assign cfg.phase_step = phase_step_q;

endmodule

// File: src/tpsg_phase_volt.sv
module tpsg_phase_volt
	import tpsg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
	parameter int PHASE_WIDTH      = DEF_PHASE_WIDTH
) (
	input  logic [PHASE_WIDTH-1:0] phase,
	input  logic [AMP_W-1:0]       amplitude,
	output logic signed [VOLT_W-1:0] volt
);

	localparam int IDX_W  = $clog2(4 * SINE_TABLE_DEPTH);
	localparam int KW     = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PROD_W = PHASE_WIDTH + IDX_W + 1;
	localparam int SCL_W  = AMP_W + MAG_W;

	localparam logic [PROD_W-1:0] IDX_MUL = PROD_W'(4 * SINE_TABLE_DEPTH);
	localparam logic [IDX_W-1:0]  D1 = IDX_W'(SINE_TABLE_DEPTH);
	localparam logic [IDX_W-1:0]  D2 = IDX_W'(2 * SINE_TABLE_DEPTH);
	localparam logic [IDX_W-1:0]  D3 = IDX_W'(3 * SINE_TABLE_DEPTH);
	localparam logic [KW-1:0]     DK = KW'(SINE_TABLE_DEPTH);

	// quarter-wave table, entries 0..depth inclusive
	logic [MAG_W-1:0] rom [0:SINE_TABLE_DEPTH];

	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
		localparam logic [63:0] XG = (64'(g) * PI_HALF_Q30) / 64'(SINE_TABLE_DEPTH);
		assign rom[g] = sine_q15(XG);
	end

	logic [PROD_W-1:0] idx_prod;
	logic [IDX_W-1:0]  idx;
	logic [IDX_W-1:0]  k_full;
	logic [1:0]        quad;
	logic [KW-1:0]     k;
	logic [KW-1:0]     addr;
	logic [MAG_W-1:0]  mag;
	logic [SCL_W-1:0]  scaled;
	logic [SCL_W-1:0]  rounded;
	logic [VOLT_W-1:0] v_mag;

	assign idx_prod = PROD_W'(phase) * IDX_MUL;
	assign idx      = idx_prod[PHASE_WIDTH +: IDX_W];

	always_comb begin
		if (idx < D1) begin
			quad   = 2'd0;
			k_full = idx;
		end else if (idx < D2) begin
			quad   = 2'd1;
			k_full = idx - D1;
		end else if (idx < D3) begin
			quad   = 2'd2;
			k_full = idx - D2;
		end else begin
			quad   = 2'd3;
			k_full = idx - D3;
		end
	end

	assign k    = k_full[KW-1:0];
	// odd quadrants run the table backwards
	assign addr = quad[0] ? (DK - k) : k;
	assign mag  = rom[addr];

	assign scaled  = SCL_W'(amplitude) * SCL_W'(mag);
	assign rounded = scaled + SCL_W'(64);
	assign v_mag   = VOLT_W'(rounded[SCL_W-1:ROUND_SHIFT]);
	assign volt    = quad[1] ? -signed'(v_mag) : signed'(v_mag);

endmodule

// File: src/three_phase_sine_generator.sv
// Channel   Dir  Signals                        Contents
// --------  ---  -----------------------------  --------------------------------------
// s_axis    in   s_tvalid s_tready s_tdata[7:0]  tick
// m_axis    out  m_tvalid m_tready m_tdata      elapsed_ticks, volt_a/b/c, volt_ab/bc/ca
// apb       in   psel penable pwrite paddr ...   amplitude (0x0), phase_step (0x4)
//
// One sample set per clock while the output is not stalled: an input stage samples
// the phase accumulator and makes the three phase angles, then the table lookup,
// amplitude multiply and line differences feed the output register.
// arst_n clears the accumulator, tick count and pipeline and loads the register defaults.
// A stalled output holds its transfer; the input stage keeps taking items until it is
// also full.
module three_phase_sine_generator
	import tpsg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
	parameter int PHASE_WIDTH      = DEF_PHASE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [0] tick, rest zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [31:0] elapsed_ticks, [50:32] volt_a, [69:51] volt_b, [88:70] volt_c,
	// [108:89] volt_ab, [128:109] volt_bc, [148:129] volt_ca, rest zero
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	localparam int PW     = PHASE_WIDTH;
	localparam int PSUM_W = ((PW > STEP_W) ? PW : STEP_W) + 1;
	localparam logic [63:0] FULL_L       = 64'd1 << PW;
	localparam logic [63:0] THIRD_L      = (64'd2 * FULL_L + 64'd3) / 64'd6;
	localparam logic [63:0] TWO_THIRDS_L = (64'd4 * FULL_L + 64'd3) / 64'd6;
	localparam logic [PW-1:0] THIRD      = THIRD_L[PW-1:0];
	localparam logic [PW-1:0] TWO_THIRDS = TWO_THIRDS_L[PW-1:0];

	cfg_t cfg;

	tpsg_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [PW-1:0]     phase_acc_q;
	logic [TICK_W-1:0] tick_total_q;
	logic [PSUM_W-1:0] phase_sum;
	logic [TICK_W-1:0] tick_next;
	logic              in_xfer;
	logic              out_ready;
	logic              tick;

	logic              valid_s1;
	logic [PW-1:0]     phase_a_s1;
	logic [PW-1:0]     phase_b_s1;
	logic [PW-1:0]     phase_c_s1;
	logic [TICK_W-1:0] elapsed_s1;

	logic                    m_tvalid_s2;
	logic [M_TDATA_W-1:0]    m_tdata_s2;

	assign tick      = s_tdata[0];
	assign out_ready = !m_tvalid_s2 || m_tready;
	assign s_tready  = !valid_s1 || out_ready;
	assign in_xfer   = s_tvalid && s_tready;
	assign phase_sum = PSUM_W'(phase_acc_q) + PSUM_W'(cfg.phase_step);
	assign tick_next = tick_total_q + TICK_W'(1);

	// sample first, then advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q  <= '0;
			tick_total_q <= '0;
		end else if (in_xfer && tick) begin
			phase_acc_q  <= phase_sum[PW-1:0];
			tick_total_q <= tick_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			phase_a_s1 <= phase_acc_q;
			phase_b_s1 <= phase_acc_q - THIRD;
			phase_c_s1 <= phase_acc_q - TWO_THIRDS;
			elapsed_s1 <= tick ? tick_next : tick_total_q;
		end
	end

	logic signed [VOLT_W-1:0] volt_a;
	logic signed [VOLT_W-1:0] volt_b;
	logic signed [VOLT_W-1:0] volt_c;
	logic signed [LINE_W-1:0] volt_ab;
	logic signed [LINE_W-1:0] volt_bc;
	logic signed [LINE_W-1:0] volt_ca;

	tpsg_phase_volt #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.PHASE_WIDTH      (PHASE_WIDTH)
	) u_volt_a (
		.phase     (phase_a_s1),
		.amplitude (cfg.amplitude),
		.volt      (volt_a)
	);

	tpsg_phase_volt #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.PHASE_WIDTH      (PHASE_WIDTH)
	) u_volt_b (
		.phase     (phase_b_s1),
		.amplitude (cfg.amplitude),
		.volt      (volt_b)
	);

	tpsg_phase_volt #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.PHASE_WIDTH      (PHASE_WIDTH)
	) u_volt_c (
		.phase     (phase_c_s1),
		.amplitude (cfg.amplitude),
		.volt      (volt_c)
	);

	assign volt_ab = LINE_W'(volt_a) - LINE_W'(volt_b);
	assign volt_bc = LINE_W'(volt_b) - LINE_W'(volt_c);
	assign volt_ca = LINE_W'(volt_c) - LINE_W'(volt_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_s2 <= 1'b0;
		end else if (out_ready) begin
			m_tvalid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && out_ready) begin
			m_tdata_s2 <= {(M_TDATA_W - PAYLOAD_W)'(0), volt_ca, volt_bc, volt_ab,
				volt_c, volt_b, volt_a, elapsed_s1};
		end
	end

	assign m_tvalid = m_tvalid_s2;
	assign m_tdata  = m_tdata_s2;

endmodule

// File: src/tpsg_checker.sv
module tpsg_checker
	import tpsg_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	logic                     out_xfer;
	logic                     seen_q;
	logic [TICK_W-1:0]        last_ticks_q;
	logic [TICK_W-1:0]        tick_delta;
	logic signed [LINE_W-1:0] line_sum;
	logic signed [VOLT_W-1:0] va;

	assign out_xfer   = m_tvalid && m_tready;
	assign tick_delta = m_tdata[OFS_TICKS +: TICK_W] - last_ticks_q;
	assign line_sum   = signed'(m_tdata[OFS_AB +: LINE_W]) + signed'(m_tdata[OFS_BC +: LINE_W])
		+ signed'(m_tdata[OFS_CA +: LINE_W]);
	assign va         = signed'(m_tdata[OFS_A +: VOLT_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_ticks_q <= '0;
		end else if (out_xfer) begin
			seen_q       <= 1'b1;
			last_ticks_q <= m_tdata[OFS_TICKS +: TICK_W];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transfer dropped or changed while stalled");

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	a_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_q |-> tick_delta == TICK_W'(0) || tick_delta == TICK_W'(1))
		else $error("elapsed tick count jumped between transfers");

	a_lines: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> line_sum == LINE_W'(0))
		else $error("line voltages do not sum to zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> va <= VOLT_W'(261888) && va >= -VOLT_W'(261888))
		else $error("phase A voltage out of range");

endmodule

bind three_phase_sine_generator tpsg_checker u_tpsg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
